@@ design/asbg_pkg.sv @@
// shared types and constants for the authentication session budget guard
package asbg_pkg;

    localparam int unsigned TimeW  = 64;
    localparam int unsigned ByteW  = 64;
    localparam int unsigned CountW = 32;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_BYTES    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ATTEMPTS = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ROUNDS   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MESSAGES = 3'd4;

    localparam logic [TimeW-1:0]  RST_TIMEOUT  = 64'd600000;
    localparam logic [ByteW-1:0]  RST_BYTES    = 64'd262144;
    localparam logic [CountW-1:0] RST_ATTEMPTS = 32'd20;
    localparam logic [CountW-1:0] RST_ROUNDS   = 32'd32;
    localparam logic [CountW-1:0] RST_MESSAGES = 32'd64;

    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_CHECK    = 2'd1;
    localparam logic [1:0] REQ_RESERVE  = 2'd2;
    localparam logic [1:0] REQ_COMPLETE = 2'd3;

    localparam logic [1:0] KIND_MESSAGE = 2'd0;
    localparam logic [1:0] KIND_ATTEMPT = 2'd1;
    localparam logic [1:0] KIND_ROUND   = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [1:0] DEC_ALLOW      = 2'd0;
    localparam logic [1:0] DEC_DISCONNECT = 2'd1;
    localparam logic [1:0] DEC_IGNORE     = 2'd2;

    localparam logic [2:0] RSN_NONE     = 3'd0;
    localparam logic [2:0] RSN_TIMEOUT  = 3'd1;
    localparam logic [2:0] RSN_ATTEMPTS = 3'd2;
    localparam logic [2:0] RSN_ROUNDS   = 3'd3;
    localparam logic [2:0] RSN_MESSAGES = 3'd4;
    localparam logic [2:0] RSN_BYTES    = 3'd5;

    typedef struct packed {
        logic [TimeW-1:0]  timeout_ms;
        logic [ByteW-1:0]  byte_limit;
        logic [CountW-1:0] attempt_limit;
        logic [CountW-1:0] round_limit;
        logic [CountW-1:0] message_limit;
    } t_cfg;

    typedef struct packed {
        logic              started;
        logic              done;
        logic [2:0]        stored_reason;
        logic [TimeW-1:0]  start_time;
        logic [CountW-1:0] attempt_count;
        logic [CountW-1:0] round_count;
        logic [CountW-1:0] message_count;
        logic [ByteW-1:0]  byte_count;
    } t_state;

    typedef struct packed {
        logic       status;
        logic [1:0] decision;
        logic [2:0] reason;
        logic       complete_ok;
    } t_result;

endpackage

@@ design/asbg_step.sv @@
// next session state and result for one request
module asbg_step import asbg_pkg::*; (
    input  t_cfg                i_cfg,
    input  t_state              i_state,
    input  logic [1:0]          i_req_type,
    input  logic [1:0]          i_event_kind,
    input  logic [ByteW-1:0]    i_message_bytes,
    input  logic [TimeW-1:0]    i_now_ms,
    output t_state              o_state,
    output t_result             o_result
);

    function automatic logic [2:0] count_reason(
        input t_cfg              cfg,
        input logic [CountW-1:0] attempts,
        input logic [CountW-1:0] rounds,
        input logic [CountW-1:0] messages,
        input logic [ByteW-1:0]  bytes
    );
        logic [2:0] r;
        r = RSN_NONE;
        if (cfg.attempt_limit != '0 && attempts > cfg.attempt_limit) begin
            r = RSN_ATTEMPTS;
        end else if (cfg.round_limit != '0 && rounds > cfg.round_limit) begin
            r = RSN_ROUNDS;
        end else if (cfg.message_limit != '0 && messages > cfg.message_limit) begin
            r = RSN_MESSAGES;
        end else if (cfg.byte_limit != '0 && bytes > cfg.byte_limit) begin
            r = RSN_BYTES;
        end
        return r;
    endfunction

    function automatic logic [CountW-1:0] inc_sat(input logic [CountW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    logic [TimeW-1:0]  elapsed;
    logic              timeout_hit;
    logic [2:0]        pre_reason;
    logic [2:0]        post_reason;
    logic [ByteW:0]    byte_sum;
    logic [ByteW-1:0]  bytes_sat;
    logic [CountW-1:0] msg_inc;
    logic [CountW-1:0] att_inc;
    logic [CountW-1:0] rnd_inc;

    assign elapsed     = (i_now_ms >= i_state.start_time) ? i_now_ms - i_state.start_time : '0;
    assign timeout_hit = (i_cfg.timeout_ms != '0) && (elapsed >= i_cfg.timeout_ms);

    always_comb begin
        if (i_state.stored_reason != RSN_NONE) begin
            pre_reason = i_state.stored_reason;
        end else if (timeout_hit) begin
            pre_reason = RSN_TIMEOUT;
        end else begin
            pre_reason = count_reason(i_cfg, i_state.attempt_count, i_state.round_count,
                                      i_state.message_count, i_state.byte_count);
        end
    end

    // saturating counter updates for a reserve
    assign byte_sum  = {1'b0, i_state.byte_count} + {1'b0, i_message_bytes};
    assign bytes_sat = byte_sum[ByteW] ? '1 : byte_sum[ByteW-1:0];
    assign msg_inc   = inc_sat(i_state.message_count);
    assign att_inc   = (i_event_kind == KIND_ATTEMPT) ? inc_sat(i_state.attempt_count)
                                                      : i_state.attempt_count;
    assign rnd_inc   = (i_event_kind == KIND_ROUND) ? inc_sat(i_state.round_count)
                                                    : i_state.round_count;
    // timeout already ruled out when the reserve goes ahead
    assign post_reason = count_reason(i_cfg, att_inc, rnd_inc, msg_inc, bytes_sat);

    always_comb begin
        o_state              = i_state;
        o_result.status      = 1'b0;
        o_result.decision    = DEC_ALLOW;
        o_result.complete_ok = 1'b0;
        if (i_req_type == REQ_START) begin
            o_state.started       = 1'b1;
            o_state.done          = 1'b0;
            o_state.stored_reason = RSN_NONE;
            o_state.start_time    = i_now_ms;
            o_state.attempt_count = '0;
            o_state.round_count   = '0;
            o_state.message_count = '0;
            o_state.byte_count    = '0;
        end else if (!i_state.started
                     || (i_req_type == REQ_RESERVE && i_event_kind == KIND_INVALID)) begin
            o_result.status = 1'b1;
        end else if (i_req_type == REQ_COMPLETE) begin
            if (i_state.stored_reason == RSN_NONE) begin
                o_state.done         = 1'b1;
                o_result.complete_ok = 1'b1;
            end
        end else if (i_state.done) begin
            o_result.decision = DEC_IGNORE;
        end else if (pre_reason != RSN_NONE) begin
            o_state.stored_reason = pre_reason;
            o_result.decision     = DEC_DISCONNECT;
        end else if (i_req_type == REQ_RESERVE) begin
            o_state.message_count = msg_inc;
            o_state.byte_count    = bytes_sat;
            o_state.attempt_count = att_inc;
            o_state.round_count   = rnd_inc;
            o_state.stored_reason = post_reason;
            o_result.decision     = (post_reason != RSN_NONE) ? DEC_DISCONNECT : DEC_ALLOW;
        end
        o_result.reason = o_state.stored_reason;
    end

endmodule

@@ design/auth_session_budget_guard.sv @@
// top level of the authentication session budget guard
// each accepted item's result is registered into the output register, or into the skid register while a result waits
// throughput: one item per cycle; while a result waits one more item goes to a skid register,
// then the input stalls until the skid register has moved into the output register
// the session state updates in the same cycle as the item, so the next item sees it at once
// reset: synchronous active low; limits return to defaults, session not started, outputs empty
module auth_session_budget_guard import asbg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_req_type,
    input  logic [1:0]          i_event_kind,
    input  logic [ByteW-1:0]    i_message_bytes,
    input  logic [TimeW-1:0]    i_now_ms,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_status,
    output logic [1:0]          o_decision,
    output logic [2:0]          o_reason,
    output logic                o_complete_ok
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_fire;
    logic    out_fire;

    asbg_step u_step (
        .i_cfg           (r_cfg),
        .i_state         (r_state),
        .i_req_type      (i_req_type),
        .i_event_kind    (i_event_kind),
        .i_message_bytes (i_message_bytes),
        .i_now_ms        (i_now_ms),
        .o_state         (n_state),
        .o_result        (n_result)
    );

    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms    <= RST_TIMEOUT;
            r_cfg.byte_limit    <= RST_BYTES;
            r_cfg.attempt_limit <= RST_ATTEMPTS;
            r_cfg.round_limit   <= RST_ROUNDS;
            r_cfg.message_limit <= RST_MESSAGES;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TIMEOUT:  r_cfg.timeout_ms    <= i_cfg_data;
                CFG_BYTES:    r_cfg.byte_limit    <= i_cfg_data;
                CFG_ATTEMPTS: r_cfg.attempt_limit <= i_cfg_data[CountW-1:0];
                CFG_ROUNDS:   r_cfg.round_limit   <= i_cfg_data[CountW-1:0];
                CFG_MESSAGES: r_cfg.message_limit <= i_cfg_data[CountW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire;
                if (in_fire) begin
                    r_out <= n_result;
                end
            end
        end else if (in_fire) begin
            r_skid       <= n_result;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_decision    = r_out.decision;
    assign o_reason      = r_out.reason;
    assign o_complete_ok = r_out.complete_ok;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_done_no_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.done |-> (r_state.stored_reason == RSN_NONE && r_state.started))
        else $error("complete session carries a reason or was never started");

    a_reason_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stored_reason != RSN_NONE) |-> r_state.started)
        else $error("reason stored without a session");

    a_reason_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_req_type != REQ_START && r_state.stored_reason != RSN_NONE)
        |=> $stable(r_state.stored_reason))
        else $error("stored reason changed without a start");

    a_complete_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.complete_ok) |-> (r_out.reason == RSN_NONE && !r_out.status))
        else $error("complete accepted with a reason or an error");

endmodule

@@ verif/asbg_checker.sv @@
`timescale 1ns / 1ps
// session budget checker: mirrors the limits, predicts each result and compares it
module asbg_checker import asbg_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [1:0]          i_req_type,
    input  logic [1:0]          i_event_kind,
    input  logic [ByteW-1:0]    i_message_bytes,
    input  logic [TimeW-1:0]    i_now_ms,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic                i_status,
    input  logic [1:0]          i_decision,
    input  logic [2:0]          i_reason,
    input  logic                i_complete_ok,
    output int                  o_errors,
    output int                  o_pending
);

    t_cfg    limits;
    t_state  session;
    t_result expected_results[$];
    int      errors = 0;

    function automatic logic [2:0] exhaustion_reason(input logic [TimeW-1:0] now);
        logic [TimeW-1:0] elapsed;
        elapsed = (now >= session.start_time) ? now - session.start_time : '0;
        if (session.stored_reason != RSN_NONE)
            return session.stored_reason;
        if (limits.timeout_ms != '0 && elapsed >= limits.timeout_ms)
            return RSN_TIMEOUT;
        if (limits.attempt_limit != '0 && session.attempt_count > limits.attempt_limit)
            return RSN_ATTEMPTS;
        if (limits.round_limit != '0 && session.round_count > limits.round_limit)
            return RSN_ROUNDS;
        if (limits.message_limit != '0 && session.message_count > limits.message_limit)
            return RSN_MESSAGES;
        if (limits.byte_limit != '0 && session.byte_count > limits.byte_limit)
            return RSN_BYTES;
        return RSN_NONE;
    endfunction

    function automatic t_result budget_step(input logic [1:0] req, input logic [1:0] kind,
                                            input logic [ByteW-1:0] bytes,
                                            input logic [TimeW-1:0] now);
        t_result    res;
        logic [2:0] found;
        res = '0;
        if (req == REQ_START) begin
            session = '0;
            session.started = 1'b1;
            session.start_time = now;
        end else if (!session.started || (req == REQ_RESERVE && kind == KIND_INVALID)) begin
            res.status = 1'b1;
        end else if (req == REQ_COMPLETE) begin
            if (session.stored_reason == RSN_NONE) begin
                session.done = 1'b1;
                res.complete_ok = 1'b1;
            end
        end else if (session.done) begin
            res.decision = DEC_IGNORE;
        end else begin
            found = exhaustion_reason(now);
            if (found != RSN_NONE) begin
                session.stored_reason = found;
                res.decision = DEC_DISCONNECT;
            end else if (req == REQ_RESERVE) begin
                // counters saturate rather than wrap
                if (session.message_count != '1)
                    session.message_count = session.message_count + 1'b1;
                session.byte_count = (bytes > ~session.byte_count) ? '1
                                     : session.byte_count + bytes;
                if (kind == KIND_ATTEMPT && session.attempt_count != '1)
                    session.attempt_count = session.attempt_count + 1'b1;
                if (kind == KIND_ROUND && session.round_count != '1)
                    session.round_count = session.round_count + 1'b1;
                session.stored_reason = exhaustion_reason(now);
                if (session.stored_reason != RSN_NONE)
                    res.decision = DEC_DISCONNECT;
            end
        end
        res.reason = session.stored_reason;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            limits = '{RST_TIMEOUT, RST_BYTES, RST_ATTEMPTS, RST_ROUNDS, RST_MESSAGES};
            session = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual status %0d decision %0d",
                             $time, i_status, i_decision);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_status);
                    check_field("decision", want.decision, i_decision);
                    check_field("reason", want.reason, i_reason);
                    check_field("complete_ok", want.complete_ok, i_complete_ok);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(budget_step(i_req_type, i_event_kind,
                                                       i_message_bytes, i_now_ms));
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_TIMEOUT:  limits.timeout_ms    = i_cfg_data;
                    CFG_BYTES:    limits.byte_limit    = i_cfg_data;
                    CFG_ATTEMPTS: limits.attempt_limit = i_cfg_data[CountW-1:0];
                    CFG_ROUNDS:   limits.round_limit   = i_cfg_data[CountW-1:0];
                    CFG_MESSAGES: limits.message_limit = i_cfg_data[CountW-1:0];
                    default: ;
                endcase
            end
        end
        o_errors <= errors;
        o_pending <= expected_results.size();
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// testbench top: clock, reset, session request stimulus and the final verdict
module tb;
    import asbg_pkg::*;

    localparam logic [63:0] ALL_ONES = '1;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_req_type;
    logic [1:0]          i_event_kind;
    logic [ByteW-1:0]    i_message_bytes;
    logic [TimeW-1:0]    i_now_ms;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_status;
    logic [1:0]          o_decision;
    logic [2:0]          o_reason;
    logic                o_complete_ok;

    int          errors;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          hold_go = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [63:0] cur_now;

    always #1 i_clk = ~i_clk;

    auth_session_budget_guard i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_event_kind(i_event_kind),
        .i_message_bytes(i_message_bytes), .i_now_ms(i_now_ms),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_decision(o_decision), .o_reason(o_reason),
        .o_complete_ok(o_complete_ok)
    );

    asbg_checker budget_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_req_type(i_req_type), .i_event_kind(i_event_kind),
        .i_message_bytes(i_message_bytes), .i_now_ms(i_now_ms),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_decision(o_decision), .i_reason(o_reason),
        .i_complete_ok(o_complete_ok),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls, plus a long hold-off when asked for
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic offer(input logic [1:0] req, input logic [1:0] kind,
                         input logic [63:0] bytes, input logic [63:0] now);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_event_kind <= kind;
        i_message_bytes <= bytes;
        i_now_ms <= now;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic program_limits(input logic [63:0] timeout, input logic [63:0] bytes,
                                  input logic [63:0] attempts, input logic [63:0] rounds,
                                  input logic [63:0] messages);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data <= timeout;
        @(posedge i_clk);
        i_cfg_index <= CFG_BYTES;
        i_cfg_data <= bytes;
        @(posedge i_clk);
        i_cfg_index <= CFG_ATTEMPTS;
        i_cfg_data <= attempts;
        @(posedge i_clk);
        i_cfg_index <= CFG_ROUNDS;
        i_cfg_data <= rounds;
        @(posedge i_clk);
        i_cfg_index <= CFG_MESSAGES;
        i_cfg_data <= messages;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic program_random_limits(input int zero_pct);
        program_limits(($urandom_range(99) < zero_pct) ? 64'd0 : 64'($urandom_range(1, 3000)),
                       ($urandom_range(99) < zero_pct) ? 64'd0 : 64'($urandom_range(1, 5000)),
                       ($urandom_range(99) < zero_pct) ? 64'd0 : 64'($urandom_range(1, 8)),
                       ($urandom_range(99) < zero_pct) ? 64'd0 : 64'($urandom_range(1, 8)),
                       ($urandom_range(99) < zero_pct) ? 64'd0 : 64'($urandom_range(1, 12)));
    endtask

    // mostly reserves and checks on a moving clock, with restarts and odd times mixed in
    task automatic session_traffic(input int n, input int time_step, input int byte_step);
        logic [1:0]  req;
        logic [1:0]  kind;
        logic [63:0] bytes;
        logic [63:0] now;
        int          pick;
        repeat (n) begin
            pick = $urandom_range(99);
            req = (pick < 6) ? REQ_START : (pick < 30) ? REQ_CHECK
                  : (pick < 92) ? REQ_RESERVE : REQ_COMPLETE;
            pick = $urandom_range(9);
            kind = (pick < 3) ? KIND_MESSAGE : (pick < 6) ? KIND_ATTEMPT
                   : (pick < 9) ? KIND_ROUND : KIND_INVALID;
            pick = $urandom_range(99);
            bytes = (pick < 80) ? 64'($urandom_range(byte_step))
                    : (pick < 95) ? {$urandom, $urandom} : ALL_ONES;
            cur_now = cur_now + $urandom_range(time_step);
            if (req == REQ_START && $urandom_range(9) == 0)
                cur_now = {$urandom, $urandom};
            now = ($urandom_range(24) == 0) ? {$urandom, $urandom} : cur_now;
            offer(req, kind, bytes, now);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_TIMEOUT;
        i_cfg_data = '0;
        i_req_type = REQ_CHECK;
        i_event_kind = KIND_MESSAGE;
        i_message_bytes = '0;
        i_now_ms = '0;
        cur_now = '0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // not started, invalid kind, byte saturation, wrapped time, complete, timeout
        offer(REQ_CHECK, KIND_MESSAGE, 64'd0, 64'd0);
        offer(REQ_RESERVE, KIND_MESSAGE, 64'd5, 64'd0);
        offer(REQ_COMPLETE, KIND_MESSAGE, 64'd0, 64'd0);
        offer(REQ_START, KIND_MESSAGE, 64'd0, 64'd1000);
        offer(REQ_RESERVE, KIND_INVALID, 64'd7, 64'd1000);
        offer(REQ_RESERVE, KIND_MESSAGE, 64'd100, 64'd1001);
        offer(REQ_RESERVE, KIND_ATTEMPT, 64'd0, 64'd1002);
        offer(REQ_RESERVE, KIND_ROUND, ALL_ONES, 64'd1003);
        offer(REQ_CHECK, KIND_MESSAGE, 64'd0, 64'd1004);
        offer(REQ_COMPLETE, KIND_MESSAGE, 64'd0, 64'd1005);
        offer(REQ_START, KIND_MESSAGE, 64'd0, 64'hFFFF_FFFF_FFFF_FFF0);
        offer(REQ_CHECK, KIND_MESSAGE, 64'd0, 64'd0);
        offer(REQ_CHECK, KIND_MESSAGE, 64'd0, ALL_ONES);
        offer(REQ_COMPLETE, KIND_MESSAGE, 64'd0, 64'd0);
        offer(REQ_CHECK, KIND_MESSAGE, 64'd0, 64'd0);
        offer(REQ_RESERVE, KIND_ATTEMPT, 64'd3, 64'd0);
        offer(REQ_COMPLETE, KIND_MESSAGE, 64'd0, 64'd0);
        offer(REQ_START, KIND_MESSAGE, 64'd0, 64'd0);
        offer(REQ_CHECK, KIND_MESSAGE, 64'd0, 64'd599999);
        offer(REQ_CHECK, KIND_MESSAGE, 64'd0, 64'd600000);

        // attempts, rounds and messages each exhausted in turn
        program_limits(64'd0, 64'd0, 64'd1, 64'd1, 64'd2);
        offer(REQ_START, KIND_MESSAGE, 64'd0, 64'd10);
        offer(REQ_RESERVE, KIND_ATTEMPT, 64'd1, 64'd11);
        offer(REQ_RESERVE, KIND_ATTEMPT, 64'd1, 64'd12);
        offer(REQ_START, KIND_MESSAGE, 64'd0, 64'd20);
        offer(REQ_RESERVE, KIND_ROUND, 64'd1, 64'd21);
        offer(REQ_RESERVE, KIND_ROUND, 64'd1, 64'd22);
        offer(REQ_START, KIND_MESSAGE, 64'd0, 64'd30);
        offer(REQ_RESERVE, KIND_MESSAGE, 64'd1, 64'd31);
        offer(REQ_RESERVE, KIND_MESSAGE, 64'd1, 64'd32);
        offer(REQ_RESERVE, KIND_MESSAGE, 64'd1, 64'd33);

        // tight limits, sender flat out against a long receiver hold-off
        program_random_limits(0);
        hold_go++;
        session_traffic(170, 200, 1500);

        program_limits(RST_TIMEOUT, RST_BYTES, 64'(RST_ATTEMPTS), 64'(RST_ROUNDS),
                       64'(RST_MESSAGES));
        idle_pct = 86;
        session_traffic(170, 40000, 30000);

        program_limits(64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
        idle_pct = 0;
        stall_pct = 86;
        session_traffic(170, 1000000, 1 << 20);

        program_limits(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        idle_pct = 23;
        stall_pct = 23;
        session_traffic(170, 1000000, 1 << 20);

        program_random_limits(25);
        idle_pct = 0;
        stall_pct = 0;
        session_traffic(170, 150, 1500);

        program_random_limits(0);
        idle_pct = 23;
        stall_pct = 23;
        session_traffic(170, 200, 1500);

        drain();
        repeat (4) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
